// File: src/pga_pkg.sv
// Package for the premultiplied gamma adjust block: operation codes, the
// queued item type and shared constants. Depends on nothing.
package pga_pkg;

  typedef enum logic [2:0] {
    OP_PIXEL    = 3'd0,
    OP_WR_BLUE  = 3'd1,
    OP_WR_GREEN = 3'd2,
    OP_WR_RED   = 3'd3,
    OP_WR_RECIP = 3'd4
  } op_t;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned NUM_CHAN    = 3;
  localparam logic [7:0]  BYTE_MAX    = 8'hff;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [7:0]  index;
    logic [15:0] data;
    logic [31:0] pixel;
    logic        last;
    logic        opaque;
    logic        zero;
  } item_t;

  function automatic op_t gamma_op(input logic [1:0] chan);
    op_t op;
    case (chan)
      2'd0:    op = OP_WR_BLUE;
      2'd1:    op = OP_WR_GREEN;
      2'd2:    op = OP_WR_RED;
      default: op = OP_PIXEL;
    endcase
    return op;
  endfunction

endpackage

// File: src/pga_if.sv
// Request and result channel interfaces of the premultiplied gamma adjust
// block. Valid/ready handshake; no dependencies beyond the logic types.
interface pga_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  table_index;
  logic [15:0] table_data;
  logic [31:0] pixel;
  logic        last;

  modport source(output valid, command, table_index, table_data, pixel, last,
                 input ready);
  modport sink(input valid, command, table_index, table_data, pixel, last,
               output ready);
endinterface

interface pga_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        last_out;

  modport source(output valid, pixel_out, last_out, input ready);
  modport sink(input valid, pixel_out, last_out, output ready);
endinterface

// File: src/premultiplied_gamma_adjust.sv
// Top level of the premultiplied gamma adjust block. Uses pga_pkg, pga_if,
// pga_front, pga_fifo and pga_back.
//
// This block applies loadable per-channel gamma tables to premultiplied
// ARGB32 pixels at one request per clock. A request either writes one entry
// of the blue, green or red gamma table or of the 16-bit reciprocal-of-alpha
// table (no result), or carries a pixel that yields exactly one result with
// alpha unchanged and the last flag copied. Opaque pixels map each channel
// straight through its table; the all-zero pixel stays zero; any other pixel
// is un-premultiplied through the reciprocal table, looked up, and scaled back
// by alpha, with channels above alpha taking the top entry plus the excess and
// every channel saturating at 255. Commands 5 to 7 are dropped. Tables must be
// loaded before pixels read them. Table writes are carried through the same
// pipeline as pixels, so a write takes effect for every pixel requested after
// it and for none requested before it. A new request is taken every cycle while
// the result side keeps up; a request passes to its result through the input
// register, queue, reciprocal read, index multiply, gamma read and rescale
// multiply, and a stall on the result side holds the back pipeline while the
// two-entry queue and the input register absorb up to three more requests.
module premultiplied_gamma_adjust
  import pga_pkg::*;
(
  input logic       clk,
  input logic       rst,
  pga_req_if.sink   req,
  pga_res_if.source res
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  pga_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pga_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pga_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .res       (res)
  );

endmodule

// File: src/pga_ram.sv
// Generic single write port, single read port RAM with registered read.
// Stand-alone; no package needed.
module pga_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/pga_front.sv
// Front end: registers each request, drops unused commands and classifies
// pixels as opaque or all zero. Uses pga_pkg and pga_req_if.
module pga_front
  import pga_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pga_req_if.sink    req,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  logic  held;
  logic  held_next;
  item_t item;
  logic  take;

  assign req.ready  = !held || push_ready;
  assign take       = req.valid && req.ready;
  assign push_valid = held;
  assign push_item  = item;

  always_comb begin
    held_next = held;
    if (take) begin
      held_next = (req.command <= OP_WR_RECIP);
    end else if (push_ready) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.op     <= op_t'(req.command);
      item.index  <= req.table_index;
      item.data   <= req.table_data;
      item.pixel  <= req.pixel;
      item.last   <= req.last;
      item.opaque <= (req.pixel[31:24] == ALPHA_OPAQUE);
      item.zero   <= (req.pixel == 32'd0);
    end
  end

endmodule

// File: src/pga_fifo.sv
// Two-entry queue between the front end and the back end.
// Uses pga_pkg for the item type.
module pga_fifo
  import pga_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

// File: src/pga_back.sv
// Back end: four-stage pipeline that owns the four tables, performs table
// writes in order with pixel reads, and drives the output register.
// Uses pga_pkg, pga_ram and pga_res_if.
module pga_back
  import pga_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  item_t    pop_item,
  pga_res_if.source res
);

  logic        en;
  logic        pop;

  logic        s1_valid;
  item_t       s1_item;
  logic [15:0] recip_rdata;
  logic [23:0] s1_prod [NUM_CHAN];
  logic [7:0]  s1_idx  [NUM_CHAN];
  logic        s1_gt   [NUM_CHAN];
  logic [8:0]  s1_adj;

  logic        s2_valid;
  item_t       s2_item;
  logic [7:0]  s2_idx  [NUM_CHAN];
  logic        s2_gt   [NUM_CHAN];
  logic [8:0]  s2_adj;

  logic        s3_valid;
  item_t       s3_item;
  logic        s3_gt   [NUM_CHAN];
  logic [8:0]  s3_adj;
  logic [7:0]  gamma_rdata [NUM_CHAN];
  logic [7:0]  top_entry   [NUM_CHAN];

  logic [7:0]  operand  [NUM_CHAN];
  logic [16:0] scaled   [NUM_CHAN];
  logic [7:0]  excess   [NUM_CHAN];
  logic [9:0]  sum      [NUM_CHAN];
  logic [7:0]  chan_res [NUM_CHAN];

  logic        out_valid;
  logic [31:0] out_pixel;
  logic        out_last;

  // The whole pipeline advances together whenever the output slot frees up.
  assign en        = !out_valid || res.ready;
  assign pop_ready = en;
  assign pop       = pop_valid && en;

  assign res.valid     = out_valid;
  assign res.pixel_out = out_pixel;
  assign res.last_out  = out_last;

  // Stage 0: reciprocal table access at the queue head.
  pga_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_recip_ram (
    .clk   (clk),
    .we    (pop && (pop_item.op == OP_WR_RECIP)),
    .waddr (pop_item.index),
    .wdata (pop_item.data),
    .re    (en),
    .raddr (pop_item.pixel[31:24]),
    .rdata (recip_rdata)
  );

  // Stage 1: un-premultiply index and channel-above-alpha flags.
  always_comb begin
    s1_adj = {1'b0, s1_item.pixel[31:24]} + {8'd0, s1_item.pixel[31]};
    for (int c = 0; c < NUM_CHAN; c++) begin
      s1_prod[c] = recip_rdata * s1_item.pixel[8*c +: 8];
      s1_idx[c]  = (|s1_prod[c][23:16]) ? BYTE_MAX : s1_prod[c][15:8];
      s1_gt[c]   = (s1_item.pixel[8*c +: 8] > s1_item.pixel[31:24]);
    end
  end

  // Stage 2: gamma table access; writes land here so they stay ordered
  // with the reads of neighboring pixels.
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    logic       wr;
    logic [7:0] raddr;

    assign wr    = en && s2_valid && (s2_item.op == gamma_op(2'(c)));
    assign raddr = s2_item.opaque ? s2_item.pixel[8*c +: 8] : s2_idx[c];

    pga_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_gamma_ram (
      .clk   (clk),
      .we    (wr),
      .waddr (s2_item.index),
      .wdata (s2_item.data[7:0]),
      .re    (en),
      .raddr (raddr),
      .rdata (gamma_rdata[c])
    );

    // Copy of the top table entry, used by channels above alpha.
    always_ff @(posedge clk) begin
      if (wr && (s2_item.index == BYTE_MAX)) begin
        top_entry[c] <= s2_item.data[7:0];
      end
    end
  end

  // Stage 3: re-premultiply and saturate; all-zero pixels give zero and opaque pixels take the table value.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      operand[c] = s3_gt[c] ? top_entry[c] : gamma_rdata[c];
      scaled[c]  = operand[c] * s3_adj;
      excess[c]  = s3_gt[c] ? (s3_item.pixel[8*c +: 8] - s3_item.pixel[31:24]) : 8'd0;
      sum[c]     = {1'b0, scaled[c][16:8]} + {2'd0, excess[c]};
      if (s3_item.zero) begin
        chan_res[c] = 8'd0;
      end else if (s3_item.opaque) begin
        chan_res[c] = gamma_rdata[c];
      end else begin
        chan_res[c] = (|sum[c][9:8]) ? BYTE_MAX : sum[c][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && (s3_item.op == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item   <= pop_item;
      s2_item   <= s1_item;
      s2_adj    <= s1_adj;
      s2_idx    <= s1_idx;
      s2_gt     <= s1_gt;
      s3_item   <= s2_item;
      s3_adj    <= s2_adj;
      s3_gt     <= s2_gt;
      out_pixel <= {s3_item.pixel[31:24], chan_res[2], chan_res[1], chan_res[0]};
      out_last  <= s3_item.last;
    end
  end

endmodule
